### rtl/fpcm_pkg.sv
// Shared constants, types and codes for the framed packet command matcher.
`timescale 1ns / 1ps

package fpcm_pkg;

  // Packet geometry
  localparam int PKT_BYTES = 8;
  localparam int BYTE_W    = 8;
  localparam int TMPL_W    = 64;
  localparam int POS_W     = $clog2(PKT_BYTES + 1);
  localparam int CNT_W     = $clog2(PKT_BYTES);
  localparam int CFG_IDX_W = 2;
  localparam int CODE_W    = 2;

  localparam logic [POS_W-1:0] LAST_POS  = POS_W'(PKT_BYTES - 1);
  localparam logic [POS_W-1:0] FIRST_POS = POS_W'(1);
  localparam logic [POS_W-1:0] IDLE_POS  = '0;
  localparam logic [CNT_W-1:0] LAST_CNT  = CNT_W'(PKT_BYTES - 1);

  // Result codes
  localparam logic [CODE_W-1:0] CODE_NONE = 2'd0;
  localparam logic [CODE_W-1:0] CODE_ONE  = 2'd1;
  localparam logic [CODE_W-1:0] CODE_TWO  = 2'd2;

  // Reset values of the configuration registers
  localparam logic [BYTE_W-1:0] START_RST = 8'h00;
  localparam logic [BYTE_W-1:0] END_RST   = 8'hFF;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_BYTE,
    REG_END_BYTE,
    REG_TEMPLATE_ONE,
    REG_TEMPLATE_TWO
  } cfg_reg_t;

  // Control sequencer states
  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_COMPARE,
    ST_LOAD
  } fsm_state_t;

  // Running match flags passed along the cell chain
  typedef struct packed {
    logic one;
    logic two;
  } match_t;

endpackage

### rtl/framed_packet_command_matcher_core.sv
// A completing end byte starts the compare sweep (ST_COMPARE), then ST_LOAD registers
// its result into the output register. One byte per cycle is taken while a frame fills;
// after the end byte the input stalls while the match flags ripple through the cell
// chain, and longer while a stalled result holds the output register.
// Reset: synchronous active-low rst_n sets start byte 0, end byte 0xFF, templates 0,
// idle fill position and an empty output register.
`timescale 1ns / 1ps

module framed_packet_command_matcher_core (
  input  logic                              clk,
  input  logic                              rst_n,
  // byte input
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [fpcm_pkg::BYTE_W-1:0]       in_rx_byte,
  // result output
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [fpcm_pkg::CODE_W-1:0]       out_match_code,
  output logic                              out_command_flag,
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fpcm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fpcm_pkg::TMPL_W-1:0]       cfg_data
);
  import fpcm_pkg::*;

  // Configuration registers
  logic [BYTE_W-1:0] start_byte_r;
  logic [BYTE_W-1:0] end_byte_r;
  logic [TMPL_W-1:0] tmpl_one_r;
  logic [TMPL_W-1:0] tmpl_two_r;

  // Control state
  fsm_state_t        state_r, state_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              shift_en;
  logic              load_out;
  logic              in_fire;
  logic              is_start;
  logic              is_end;

  // Output register
  logic              out_valid_r;
  logic [CODE_W-1:0] out_code_r;
  logic [CODE_W-1:0] code_nxt;

  // Cell chain wiring
  logic [BYTE_W-1:0] chain_byte [PKT_BYTES+1];
  match_t            chain_match [PKT_BYTES+1];

  assign cfg_ready = 1'b1;

  // Configuration write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= START_RST;
      end_byte_r   <= END_RST;
      tmpl_one_r   <= '0;
      tmpl_two_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_START_BYTE:   start_byte_r <= cfg_data[BYTE_W-1:0];
        REG_END_BYTE:     end_byte_r   <= cfg_data[BYTE_W-1:0];
        REG_TEMPLATE_ONE: tmpl_one_r   <= cfg_data;
        REG_TEMPLATE_TWO: tmpl_two_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Cell chain: new bytes enter at the top cell, flags start at cell 0
  assign chain_byte[PKT_BYTES] = in_rx_byte;
  assign chain_match[0]        = '{one: 1'b1, two: 1'b1};

  for (genvar k = 0; k < PKT_BYTES; k++) begin : g_cell
    fpcm_cell u_cell (
      .clk           (clk),
      .shift_en      (shift_en),
      .byte_in       (chain_byte[k+1]),
      .tmpl_one_byte (tmpl_one_r[k*BYTE_W +: BYTE_W]),
      .tmpl_two_byte (tmpl_two_r[k*BYTE_W +: BYTE_W]),
      .match_in      (chain_match[k]),
      .byte_out      (chain_byte[k]),
      .match_out     (chain_match[k+1])
    );
  end

  assign in_fire  = in_valid && !in_stall;
  assign is_start = (in_rx_byte == start_byte_r);
  assign is_end   = (in_rx_byte == end_byte_r);

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_COLLECT;
      pos_r   <= IDLE_POS;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Next state: framing rules, then compare sweep, then result load
  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    cnt_nxt   = cnt_r;
    shift_en  = 1'b0;
    load_out  = 1'b0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_COLLECT: begin
        in_stall = 1'b0;
        if (in_fire) begin
          priority if (is_start) begin
            shift_en = 1'b1;
            pos_nxt  = FIRST_POS;
          end else if (is_end && pos_r == LAST_POS) begin
            shift_en  = 1'b1;
            pos_nxt   = IDLE_POS;
            cnt_nxt   = '0;
            state_nxt = ST_COMPARE;
          end else if (is_end && pos_r < LAST_POS) begin
            pos_nxt = IDLE_POS;
          end else if (pos_r > LAST_POS) begin
            pos_nxt = IDLE_POS;
          end else if (pos_r != IDLE_POS) begin
            shift_en = 1'b1;
            pos_nxt  = pos_r + FIRST_POS;
          end else begin
            pos_nxt = pos_r;
          end
        end
      end
      ST_COMPARE: begin
        // flags pass through every cell register to reach the chain end
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == LAST_CNT) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = ST_COLLECT;
        end
      end
      default: begin
        state_nxt = ST_COLLECT;
      end
    endcase
  end

  // First template wins when both match
  always_comb begin
    priority if (chain_match[PKT_BYTES].one) begin
      code_nxt = CODE_ONE;
    end else if (chain_match[PKT_BYTES].two) begin
      code_nxt = CODE_TWO;
    end else begin
      code_nxt = CODE_NONE;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_code_r <= code_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_match_code   = out_code_r;
  assign out_command_flag = (out_code_r != CODE_NONE);

endmodule

### rtl/fpcm_cell.sv
// One frame buffer cell: holds a byte and extends the running template match.
`timescale 1ns / 1ps

module fpcm_cell (
  input  logic                          clk,
  input  logic                          shift_en,
  input  logic [fpcm_pkg::BYTE_W-1:0]   byte_in,
  input  logic [fpcm_pkg::BYTE_W-1:0]   tmpl_one_byte,
  input  logic [fpcm_pkg::BYTE_W-1:0]   tmpl_two_byte,
  input  fpcm_pkg::match_t              match_in,
  output logic [fpcm_pkg::BYTE_W-1:0]   byte_out,
  output fpcm_pkg::match_t              match_out
);
  import fpcm_pkg::*;

  logic [BYTE_W-1:0] byte_r;
  match_t            match_r;
  match_t            match_nxt;

  // Match flags ripple one cell per cycle
  always_comb begin
    match_nxt.one = match_in.one & (byte_r == tmpl_one_byte);
    match_nxt.two = match_in.two & (byte_r == tmpl_two_byte);
  end

  // Byte moves toward cell 0 on every store
  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= byte_in;
    end
    match_r <= match_nxt;
  end

  assign byte_out  = byte_r;
  assign match_out = match_r;

endmodule

### rtl/fpcm_checker.sv
// Port-level checker for the framed packet command matcher, bound to the top level.
`timescale 1ns / 1ps

module fpcm_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [fpcm_pkg::CODE_W-1:0]       out_match_code,
  input logic                              out_command_flag
);
  import fpcm_pkg::*;

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // Flag agrees with the code
  a_flag_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_command_flag == (out_match_code != CODE_NONE)))
    else $error("command flag disagrees with match code");

  // Only defined codes are reported
  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_match_code == CODE_NONE || out_match_code == CODE_ONE ||
                   out_match_code == CODE_TWO))
    else $error("undefined match code");

  // A new result only appears after the input has been held off for the compare sweep
  a_sweep_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a compare sweep");

endmodule

bind framed_packet_command_matcher_core fpcm_checker u_fpcm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_match_code   (out_match_code),
  .out_command_flag (out_command_flag)
);
